FILE: src/pidpa_pkg.sv
// ----------------------------------------------------------------------------
// pidpa_pkg
// Shared constants and helpers for the packed integer dot-product accumulator:
// register indexes, width codes, and the destination-width extend and clamp.
// ----------------------------------------------------------------------------
package pidpa_pkg;

    localparam int WORD_W    = 64;
    // exact group sum: 8 products of 64x64 plus the accumulator, with sign
    localparam int SUM_W     = 136;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 2;
    localparam int HELD_W    = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_EN    = 2'd3;

    // width codes
    localparam logic [1:0] WCODE_8  = 2'd0;
    localparam logic [1:0] WCODE_16 = 2'd1;
    localparam logic [1:0] WCODE_32 = 2'd2;
    localparam logic [1:0] WCODE_64 = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              over;
    } t_clamp;

    // all-ones mask of the destination width
    function automatic logic [WORD_W-1:0] dst_mask(input logic [1:0] code);
        logic [WORD_W-1:0] m;
        case (code)
            WCODE_8:  m = 64'h0000_0000_0000_00FF;
            WCODE_16: m = 64'h0000_0000_0000_FFFF;
            WCODE_32: m = 64'h0000_0000_FFFF_FFFF;
            WCODE_64: m = 64'hFFFF_FFFF_FFFF_FFFF;
            default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // low bits of v at destination width, sign- or zero-extended to 64 bits
    function automatic logic [WORD_W-1:0] dst_extend(input logic [WORD_W-1:0] v,
                                                      input logic [1:0] code,
                                                      input logic sgn);
        logic [WORD_W-1:0] r;
        case (code)
            WCODE_8:  r = {{56{sgn & v[7]}}, v[7:0]};
            WCODE_16: r = {{48{sgn & v[15]}}, v[15:0]};
            WCODE_32: r = {{32{sgn & v[31]}}, v[31:0]};
            WCODE_64: r = v;
            default:  r = v;
        endcase
        return r;
    endfunction

    // does the exact sum lie in the destination range
    function automatic logic dst_fits(input logic [SUM_W-1:0] t,
                                      input logic [1:0] code,
                                      input logic sgn);
        logic f;
        case (code)
            WCODE_8:  f = sgn ? (&t[SUM_W-1:7]  | ~|t[SUM_W-1:7])  : ~|t[SUM_W-1:8];
            WCODE_16: f = sgn ? (&t[SUM_W-1:15] | ~|t[SUM_W-1:15]) : ~|t[SUM_W-1:16];
            WCODE_32: f = sgn ? (&t[SUM_W-1:31] | ~|t[SUM_W-1:31]) : ~|t[SUM_W-1:32];
            WCODE_64: f = sgn ? (&t[SUM_W-1:63] | ~|t[SUM_W-1:63]) : ~|t[SUM_W-1:64];
            default:  f = 1'b1;
        endcase
        return f;
    endfunction

    // wrap or clamp the exact sum into the destination range
    function automatic t_clamp dst_clamp(input logic [SUM_W-1:0] t,
                                         input logic [1:0] code,
                                         input logic sgn,
                                         input logic sat_en);
        t_clamp            r;
        logic [WORD_W-1:0] m;
        logic [WORD_W-1:0] lim;
        m = dst_mask(code);
        if (sgn) begin
            lim = t[SUM_W-1] ? ~(m >> 1) : (m >> 1);
        end else begin
            lim = t[SUM_W-1] ? '0 : m;
        end
        r.over  = ~dst_fits(t, code, sgn);
        r.value = (sat_en && r.over) ? lim : dst_extend(t[WORD_W-1:0], code, sgn);
        return r;
    endfunction

endpackage

FILE: src/packed_int_dot_product_accumulator.sv
// ----------------------------------------------------------------------------
// packed_int_dot_product_accumulator
// Packed SIMD integer dot-product accumulator: splits two 64-bit words into
// 8/16/32/64-bit lanes, adds their dot product into a destination-width
// accumulator group by group, and reports the accumulator on a last beat.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+--------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | tdata: word_a, word_b; tlast: finish
//  m_axis   | out | m_axis_tvalid/tready    | tdata: acc_value; tuser: saturated
//  cfg      | in  | i_cfg_we (no wait)      | i_cfg_index, i_cfg_data
//
// One beat per cycle is accepted unless the pipeline holds. A last beat
// passes the input register, the lane multipliers and the word sum, then
// the accumulate and clamp stage that loads the output register.
// The whole pipeline holds only while a last beat waits at the accumulate
// stage and the output register is still full.
// Reset is synchronous; registers come up as width 8, signed, dest 32, wrap.
// ----------------------------------------------------------------------------
module packed_int_dot_product_accumulator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // [63:0] word_a, [127:64] word_b
    input  logic         s_axis_tlast,   // finish
    // output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // [63:0] acc_value
    output logic         m_axis_tuser,   // [0] saturated
    // configuration
    input  logic         i_cfg_we,
    input  logic [pidpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pidpa_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import pidpa_pkg::*;

    // configuration registers
    logic [1:0] r_src_code;
    logic       r_sgn;
    logic [1:0] r_dst_code;
    logic       r_sat_en;

    // run state
    logic [HELD_W-1:0] r_held;
    logic [WORD_W-1:0] r_acc;
    logic              r_sat;
    logic [SUM_W-1:0]  r_gsum;

    // stage 1: input register
    logic              r_a_valid, r_a_fin, r_a_first, r_a_close, r_a_neg;
    logic [WORD_W-1:0] r_a_wa, r_a_wb;

    // stage 2: lane products
    logic              r_b_valid, r_b_fin, r_b_first, r_b_close, r_b_neg;
    logic signed [17:0] r_p8  [8];
    logic signed [33:0] r_p16 [4];
    logic signed [65:0] r_p32 [2];
    logic [WORD_W-1:0]  r_p64 [4];

    // stage 3: word sum
    logic              r_c_valid, r_c_fin, r_c_first, r_c_close, r_c_neg;
    logic [SUM_W-1:0]  r_c_sum;

    // output register
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_acc;
    logic              r_out_sat;

    logic              adv;
    logic              accept;
    logic              valid_pair;

    // pipeline holds only when a last beat cannot leave
    assign adv    = ~(r_c_valid & r_c_fin & r_out_valid & ~m_axis_tready);
    assign accept = s_axis_tvalid & adv;
    assign s_axis_tready = adv;

    assign valid_pair = (r_dst_code >= r_src_code) && ((r_dst_code - r_src_code) <= 2'd2);

    // group bookkeeping and 64-bit lane magnitudes at capture
    logic [HELD_W-1:0] needed;
    logic [HELD_W-1:0] held_inc;
    logic              n_a_first, n_a_close, n_a_neg;
    logic [HELD_W-1:0] n_held;
    logic [WORD_W-1:0] n_a_wa, n_a_wb, in_wa, in_wb;
    logic              neg_a, neg_b;

    always_comb begin
        in_wa    = s_axis_tdata[63:0];
        in_wb    = s_axis_tdata[127:64];
        needed   = HELD_W'(1) << r_src_code;
        held_inc = r_held + HELD_W'(1);
        if (s_axis_tlast) begin
            n_a_first = 1'b0;
            n_a_close = (r_held != '0);
            n_held    = '0;
        end else begin
            n_a_first = (r_held == '0);
            n_a_close = (held_inc == needed);
            n_held    = n_a_close ? '0 : held_inc;
        end
        neg_a   = r_sgn & (r_src_code == WCODE_64) & in_wa[63];
        neg_b   = r_sgn & (r_src_code == WCODE_64) & in_wb[63];
        n_a_wa  = neg_a ? (~in_wa + WORD_W'(1)) : in_wa;
        n_a_wb  = neg_b ? (~in_wb + WORD_W'(1)) : in_wb;
        n_a_neg = neg_a ^ neg_b;
    end

    // lane multipliers
    logic signed [17:0] n_p8  [8];
    logic signed [33:0] n_p16 [4];
    logic signed [65:0] n_p32 [2];
    logic [WORD_W-1:0]  n_p64 [4];

    always_comb begin
        logic signed [8:0]  x8a, x8b;
        logic signed [16:0] x16a, x16b;
        logic signed [32:0] x32a, x32b;
        for (int i = 0; i < 8; i++) begin
            x8a = $signed({r_sgn & r_a_wa[8*i+7], r_a_wa[8*i +: 8]});
            x8b = $signed({r_sgn & r_a_wb[8*i+7], r_a_wb[8*i +: 8]});
            n_p8[i] = x8a * x8b;
        end
        for (int i = 0; i < 4; i++) begin
            x16a = $signed({r_sgn & r_a_wa[16*i+15], r_a_wa[16*i +: 16]});
            x16b = $signed({r_sgn & r_a_wb[16*i+15], r_a_wb[16*i +: 16]});
            n_p16[i] = x16a * x16b;
        end
        for (int i = 0; i < 2; i++) begin
            x32a = $signed({r_sgn & r_a_wa[32*i+31], r_a_wa[32*i +: 32]});
            x32b = $signed({r_sgn & r_a_wb[32*i+31], r_a_wb[32*i +: 32]});
            n_p32[i] = x32a * x32b;
        end
        // 64-bit lane: four 32x32 partials of the magnitudes
        n_p64[0] = {32'd0, r_a_wa[31:0]}  * {32'd0, r_a_wb[31:0]};
        n_p64[1] = {32'd0, r_a_wa[31:0]}  * {32'd0, r_a_wb[63:32]};
        n_p64[2] = {32'd0, r_a_wa[63:32]} * {32'd0, r_a_wb[31:0]};
        n_p64[3] = {32'd0, r_a_wa[63:32]} * {32'd0, r_a_wb[63:32]};
    end

    // sum of all lanes of one word
    logic [SUM_W-1:0] n_c_sum;

    always_comb begin
        n_c_sum = '0;
        case (r_src_code)
            WCODE_8: begin
                for (int i = 0; i < 8; i++) begin
                    n_c_sum = n_c_sum + {{(SUM_W-18){r_p8[i][17]}}, r_p8[i]};
                end
            end
            WCODE_16: begin
                for (int i = 0; i < 4; i++) begin
                    n_c_sum = n_c_sum + {{(SUM_W-34){r_p16[i][33]}}, r_p16[i]};
                end
            end
            WCODE_32: begin
                for (int i = 0; i < 2; i++) begin
                    n_c_sum = n_c_sum + {{(SUM_W-66){r_p32[i][65]}}, r_p32[i]};
                end
            end
            WCODE_64: begin
                n_c_sum = {72'd0, r_p64[0]}
                        + {40'd0, r_p64[1], 32'd0}
                        + {40'd0, r_p64[2], 32'd0}
                        + {8'd0, r_p64[3], 64'd0};
            end
            default: n_c_sum = '0;
        endcase
    end

    // accumulate, then wrap or clamp at the end of a group
    logic [SUM_W-1:0]  base, addend, total;
    logic              cin;
    t_clamp            clamp;
    logic [WORD_W-1:0] n_acc;
    logic              n_sat;

    always_comb begin
        base   = r_c_first ? {{(SUM_W-WORD_W){r_sgn & r_acc[WORD_W-1]}}, r_acc} : r_gsum;
        addend = r_c_fin ? '0 : (r_c_neg ? ~r_c_sum : r_c_sum);
        cin    = ~r_c_fin & r_c_neg;
        total  = base + addend + SUM_W'(cin);
        clamp  = dst_clamp(total, r_dst_code, r_sgn, r_sat_en);
        n_acc  = valid_pair ? clamp.value : '0;
        n_sat  = r_sat | (valid_pair & r_sat_en & clamp.over);
    end

    // configuration and run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_code  <= WCODE_8;
            r_sgn       <= 1'b1;
            r_dst_code  <= WCODE_32;
            r_sat_en    <= 1'b0;
            r_held      <= '0;
            r_acc       <= '0;
            r_sat       <= 1'b0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // pipeline valids
            if (adv) begin
                r_a_valid <= accept;
                r_b_valid <= r_a_valid;
                r_c_valid <= r_b_valid;
            end
            // output register
            if (adv && r_c_valid && r_c_fin) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                // register writes restart the run
                case (i_cfg_index)
                    CFG_SRC_WIDTH: r_src_code <= i_cfg_data;
                    CFG_SIGNED:    r_sgn      <= i_cfg_data[0];
                    CFG_DST_WIDTH: r_dst_code <= i_cfg_data;
                    CFG_SAT_EN:    r_sat_en   <= i_cfg_data[0];
                    default:       r_sat_en   <= r_sat_en;
                endcase
                r_held <= '0;
                r_acc  <= '0;
                r_sat  <= 1'b0;
            end else begin
                if (accept) begin
                    r_held <= n_held;
                end
                // accumulate stage
                if (adv && r_c_valid) begin
                    if (r_c_fin) begin
                        r_acc <= '0;
                        r_sat <= 1'b0;
                    end else if (r_c_close) begin
                        r_acc <= n_acc;
                        r_sat <= n_sat;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_fin   <= s_axis_tlast;
            r_a_first <= n_a_first;
            r_a_close <= n_a_close;
            r_a_neg   <= n_a_neg;
            r_a_wa    <= n_a_wa;
            r_a_wb    <= n_a_wb;

            r_b_fin   <= r_a_fin;
            r_b_first <= r_a_first;
            r_b_close <= r_a_close;
            r_b_neg   <= r_a_neg;
            r_p8      <= n_p8;
            r_p16     <= n_p16;
            r_p32     <= n_p32;
            r_p64     <= n_p64;

            r_c_fin   <= r_b_fin;
            r_c_first <= r_b_first;
            r_c_close <= r_b_close;
            r_c_neg   <= r_b_neg;
            r_c_sum   <= n_c_sum;

            if (r_c_valid && !r_c_close && !r_c_fin) begin
                r_gsum <= total;
            end
            if (r_c_valid && r_c_fin) begin
                r_out_acc <= r_c_close ? n_acc : r_acc;
                r_out_sat <= r_c_close ? n_sat : r_sat;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_acc;
    assign m_axis_tuser  = r_out_sat;

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the packed integer dot-product accumulator. Directed
// runs cover the reset setting, partial-group flush, clamping, invalid width
// pairs and lane extremes. Then every setting of the four registers is swept
// with random runs. A behavioral model predicts each reported sum, and a
// monitor compares every output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pidpa_pkg::*;

    localparam int DRAIN_CYCLES = 10;
    localparam int IDLE_LIMIT   = 2000;

    typedef enum int {
        FILL_RANDOM,
        FILL_SMALL,
        FILL_EXTREME,
        FILL_FLAT
    } t_fill_kind;

    typedef struct {
        logic [63:0] acc_value;
        logic        saturated;
    } t_acc_report;

    // dut signals
    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata  = '0;   // [63:0] word_a, [127:64] word_b
    logic         s_axis_tlast  = 1'b0; // finish
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;         // [63:0] acc_value
    logic         m_axis_tuser;         // [0] saturated
    logic         i_cfg_we      = 1'b0;
    logic [1:0]   i_cfg_index   = '0;
    logic [1:0]   i_cfg_data    = '0;

    // model state: registers and run in progress
    logic [1:0]   mdl_src;
    logic         mdl_sgn;
    logic [1:0]   mdl_dst;
    logic         mdl_sat_en;
    logic [63:0]  mdl_words_a [8];
    logic [63:0]  mdl_words_b [8];
    int unsigned  mdl_held;
    logic [63:0]  mdl_acc;
    logic         mdl_sat_seen;

    t_acc_report  reports_due [$];
    t_acc_report  report_want;
    int           error_count = 0;
    int           idle_cycles = 0;
    bit           tx_gaps     = 1'b1;
    bit           rx_stalls   = 1'b1;
    int unsigned  rx_left     = 0;
    int unsigned  rx_pick;

    packed_int_dot_product_accumulator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // low bits of v at the given width, sign- or zero-extended to 64 bits
    function automatic logic [63:0] to_width(logic [63:0] v, int unsigned bits, logic sgn);
        logic [63:0] m;
        m = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
        v = v & m;
        if (sgn && bits < 64 && v[bits-1]) begin
            v = v | ~m;
        end
        return v;
    endfunction

    function automatic logic [191:0] widen(logic [63:0] v, logic sgn);
        return sgn ? {{128{v[63]}}, v} : {128'd0, v};
    endfunction

    // add the dot product of the held words into the accumulator
    function automatic void fold_group();
        int unsigned sbits;
        int unsigned dbits;
        int unsigned epw;
        int unsigned wi;
        int unsigned ln;
        int          src;
        int          dst;
        logic [63:0]  dmask;
        logic [63:0]  canon;
        logic [191:0] total;
        src   = mdl_src;
        dst   = mdl_dst;
        sbits = 8 << src;
        dbits = 8 << dst;
        epw   = 64 / sbits;
        dmask = (dbits >= 64) ? '1 : ((64'd1 << dbits) - 64'd1);
        // destination must be one, two or four times the source
        if (dst < src || dst - src > 2) begin
            mdl_acc = '0;
            return;
        end
        total = widen(mdl_acc, mdl_sgn);
        for (int k = 0; k < 8; k++) begin
            wi = k / epw;
            ln = k % epw;
            if (wi < mdl_held) begin
                total = total
                      + widen(to_width(mdl_words_a[wi] >> (ln * sbits), sbits, mdl_sgn), mdl_sgn)
                      * widen(to_width(mdl_words_b[wi] >> (ln * sbits), sbits, mdl_sgn), mdl_sgn);
            end
        end
        canon = to_width(total[63:0], dbits, mdl_sgn);
        if (!mdl_sat_en) begin
            mdl_acc = canon;
        end else if (mdl_sgn) begin
            if (total == widen(canon, 1'b1)) begin
                mdl_acc = canon;
            end else begin
                mdl_acc      = total[191] ? ~(dmask >> 1) : (dmask >> 1);
                mdl_sat_seen = 1'b1;
            end
        end else begin
            if (total[191:64] == '0 && total[63:0] <= dmask) begin
                mdl_acc = total[63:0];
            end else begin
                mdl_acc      = total[191] ? '0 : dmask;
                mdl_sat_seen = 1'b1;
            end
        end
    endfunction

    // model update for one accepted input beat
    function automatic void absorb_beat(logic [63:0] a, logic [63:0] b, logic fin);
        int unsigned needed;
        t_acc_report rep;
        needed = 1 << mdl_src;
        if (!fin) begin
            mdl_words_a[mdl_held & 7] = a;
            mdl_words_b[mdl_held & 7] = b;
            mdl_held++;
        end
        if (mdl_held >= needed || fin) begin
            if (mdl_held > 0) begin
                fold_group();
            end
            mdl_held = 0;
        end
        if (fin) begin
            rep.acc_value = mdl_acc;
            rep.saturated = mdl_sat_seen;
            reports_due.insert(reports_due.size(), rep);
            mdl_acc      = '0;
            mdl_sat_seen = 1'b0;
        end
    endfunction

    // packed operand word with lanes of the chosen kind
    function automatic logic [63:0] make_word(int unsigned sbits, t_fill_kind fill);
        logic [63:0] w;
        logic [63:0] lane;
        logic [63:0] m;
        int          s;
        w = '0;
        m = (sbits >= 64) ? '1 : ((64'd1 << sbits) - 64'd1);
        case (fill)
            FILL_RANDOM: begin
                w = {$urandom, $urandom};
            end
            FILL_FLAT: begin
                w = $urandom_range(0, 1) ? '1 : '0;
            end
            default: begin
                for (int l = 0; l < 64 / sbits; l++) begin
                    if (fill == FILL_SMALL) begin
                        s    = int'($urandom_range(0, 6)) - 3;
                        lane = 64'(s);
                    end else begin
                        case ($urandom_range(0, 3))
                            0:       lane = '0;
                            1:       lane = '1;
                            2:       lane = 64'd1 << (sbits - 1);
                            default: lane = (64'd1 << (sbits - 1)) - 64'd1;
                        endcase
                    end
                    w = w | ((lane & m) << (l * sbits));
                end
            end
        endcase
        return w;
    endfunction

    // send one beat, with a random gap before it, and wait for acceptance
    task automatic send_beat(logic [63:0] a, logic [63:0] b, logic fin);
        int unsigned gap;
        int unsigned r;
        gap = 0;
        if (tx_gaps) begin
            r = $urandom_range(0, 99);
            if (r >= 92) begin
                gap = $urandom_range(8, 30);
            end else if (r >= 60) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        absorb_beat(a, b, fin);
    endtask

    // hold off the sender until every report is in and the pipeline is empty
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write all four registers back to back while the block is idle
    task automatic apply_config(logic [1:0] src, logic sgn, logic [1:0] dst, logic sat);
        logic [1:0] idx [4];
        logic [1:0] val [4];
        idx = '{CFG_SRC_WIDTH, CFG_SIGNED, CFG_DST_WIDTH, CFG_SAT_EN};
        val = '{src, {1'b0, sgn}, dst, {1'b0, sat}};
        wait_idle();
        for (int r = 0; r < 4; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[r];
            i_cfg_data  <= val[r];
            @(posedge i_clk);
            case (idx[r])
                CFG_SRC_WIDTH: mdl_src    = val[r];
                CFG_SIGNED:    mdl_sgn    = val[r][0];
                CFG_DST_WIDTH: mdl_dst    = val[r];
                CFG_SAT_EN:    mdl_sat_en = val[r][0];
                default:       ;
            endcase
            mdl_held     = 0;
            mdl_acc      = '0;
            mdl_sat_seen = 1'b0;
        end
        i_cfg_we <= 1'b0;
    endtask

    // reset setting: 8-bit signed lanes into a 32-bit wrapping accumulator
    task automatic test_reset_setting();
        send_beat(64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080, 1'b0);
        send_beat(64'hFFFF_FFFF_FFFF_FFFF, 64'h7F7F_7F7F_7F7F_7F7F, 1'b0);
        send_beat(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b1);
        // finish with no words reports zero
        send_beat('1, '1, 1'b1);
    endtask

    // 64-bit lanes: a group is 8 words, so 3 words are flushed zero-padded
    task automatic test_partial_flush();
        apply_config(WCODE_64, 1'b1, WCODE_64, 1'b0);
        send_beat(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0);
        send_beat(64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        send_beat(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        send_beat('0, '0, 1'b1);
        // unsigned all-ones products clamp at the 64-bit maximum
        apply_config(WCODE_64, 1'b0, WCODE_64, 1'b1);
        send_beat('1, '1, 1'b0);
        send_beat('1, '1, 1'b0);
        send_beat('0, '0, 1'b1);
    endtask

    // signed 16-bit lanes into 32 bits, clamped high and then low
    task automatic test_clamping();
        apply_config(WCODE_16, 1'b1, WCODE_32, 1'b1);
        send_beat(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000, 1'b0);
        send_beat(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000, 1'b0);
        send_beat('0, '0, 1'b1);
        send_beat(64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF, 1'b0);
        send_beat(64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF, 1'b0);
        send_beat('1, '1, 1'b1);
    endtask

    // destination narrower than the source or more than four times it
    task automatic test_invalid_pairs();
        apply_config(WCODE_64, 1'b1, WCODE_8, 1'b0);
        send_beat(64'h0000_0000_0000_0003, 64'h0000_0000_0000_0005, 1'b0);
        send_beat('0, '0, 1'b1);
        apply_config(WCODE_8, 1'b0, WCODE_64, 1'b1);
        send_beat('1, '1, 1'b0);
        send_beat('0, '0, 1'b1);
    endtask

    // every register setting in turn, each with random runs
    task automatic test_random_runs();
        int unsigned sbits;
        int unsigned needed;
        int unsigned run_len;
        int unsigned pick;
        int unsigned made;
        t_fill_kind  fill;
        for (int p = 0; p < 64; p++) begin
            apply_config(p[1:0], p[4], p[3:2], p[5]);
            sbits     = 8 << p[1:0];
            needed    = 1 << p[1:0];
            tx_gaps   = (p % 4) != 0;
            rx_stalls = (p % 4) != 1;
            made      = 0;
            while (made < 17) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    run_len = 0;
                end else if (pick < 80) begin
                    run_len = $urandom_range(1, 2 * needed);
                end else begin
                    run_len = $urandom_range(2 * needed, 20);
                end
                fill = t_fill_kind'($urandom_range(0, 3));
                repeat (run_len) begin
                    send_beat(make_word(sbits, fill), make_word(sbits, fill), 1'b0);
                end
                // words on a finish beat are ignored
                send_beat({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
                made += run_len + 1;
            end
            // sometimes leave an unfinished run for the next register write to drop
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    send_beat({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
                end
            end
        end
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
    endtask

    // output ready: runs of ready and stall, mostly short, a few long
    always @(posedge i_clk) begin
        if (!rx_stalls) begin
            m_axis_tready <= 1'b1;
            rx_left       <= 0;
        end else if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 65) begin
                m_axis_tready <= 1'b1;
                rx_left       <= $urandom_range(0, 4);
            end else if (rx_pick < 93) begin
                m_axis_tready <= 1'b0;
                rx_left       <= $urandom_range(0, 2);
            end else begin
                m_axis_tready <= 1'b0;
                rx_left       <= $urandom_range(10, 30);
            end
        end
    end

    // compare each output beat with the oldest predicted report
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (reports_due.size() == 0) begin
                $error("unexpected beat: acc_value %h saturated %b", m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                report_want = reports_due.pop_front();
                if (m_axis_tdata !== report_want.acc_value) begin
                    $error("acc_value: expected %h, got %h", report_want.acc_value, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser !== report_want.saturated) begin
                    $error("saturated: expected %b, got %b", report_want.saturated, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat moving and no register write
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // test sequence
    initial begin
        mdl_src      = WCODE_8;
        mdl_sgn      = 1'b1;
        mdl_dst      = WCODE_32;
        mdl_sat_en   = 1'b0;
        mdl_held     = 0;
        mdl_acc      = '0;
        mdl_sat_seen = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_setting();
        test_partial_flush();
        test_clamping();
        test_invalid_pairs();
        test_random_runs();
        wait_idle();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
src/pidpa_pkg.sv
src/packed_int_dot_product_accumulator.sv
sim/tb_top.sv
